// ----- sv/lqrw_pkg.sv -----
// Shared types, constants and helpers for the wheel drive controller.
package lqrw_pkg;

  localparam int unsigned FracBits = 16;   // fraction bits of every fixed-point value
  localparam int unsigned DataW    = 32;
  localparam int unsigned ScaleW   = 31;
  localparam int unsigned OpW      = 33;   // multiplier operand width
  localparam int unsigned ProdW    = 2 * OpW;
  localparam int unsigned AccW     = ProdW + 1;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGainFwd   = 3'd0,
    CfgGainRate  = 3'd1,
    CfgGainTurn  = 3'd2,
    CfgGainAngle = 3'd3,
    CfgGainSint  = 3'd4,
    CfgGainTint  = 3'd5,
    CfgSpeedScl  = 3'd6,
    CfgTurnScl   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DataW-1:0]  gain_forward_speed;
    logic signed [DataW-1:0]  gain_pitch_rate;
    logic signed [DataW-1:0]  gain_turn_rate;
    logic signed [DataW-1:0]  gain_pitch_angle;
    logic signed [DataW-1:0]  gain_speed_integral;
    logic signed [DataW-1:0]  gain_turn_integral;
    logic        [ScaleW-1:0] speed_scale;
    logic        [ScaleW-1:0] turn_scale;
  } cfg_t;

  typedef struct packed {
    logic signed [DataW-1:0] left_speed;
    logic signed [DataW-1:0] right_speed;
    logic signed [DataW-1:0] tilt_rate;
    logic signed [DataW-1:0] tilt_angle;
    logic signed [DataW-1:0] forward_speed_target;
    logic signed [DataW-1:0] turn_rate_target;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] left_effort;
    logic signed [DataW-1:0] right_effort;
  } out_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [DataW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [DataW-1:0] r;
    if ((&v[AccW-1:DataW-1]) || !(|v[AccW-1:DataW-1])) begin
      r = v[DataW-1:0];
    end else if (v[AccW-1]) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- sv/lqrw_mul.sv -----
// Shared signed multiplier with registered product.
module lqrw_mul (
  input  logic                               clk_i,
  input  logic signed [lqrw_pkg::OpW-1:0]    a_i,
  input  logic signed [lqrw_pkg::OpW-1:0]    b_i,
  output logic signed [lqrw_pkg::ProdW-1:0]  prod_o
);
  import lqrw_pkg::*;

  logic signed [ProdW-1:0] prod_q, prod_d;

  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ----- sv/lqrw_regs.sv -----
// Configuration register file: gains and speed and turn scales.
module lqrw_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [lqrw_pkg::CfgIdxW-1:0]  idx_i,
  input  logic [lqrw_pkg::DataW-1:0]    wdata_i,
  output lqrw_pkg::cfg_t                cfg_o
);
  import lqrw_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (cfg_idx_e'(idx_i))
        CfgGainFwd:   cfg_d.gain_forward_speed  = wdata_i;
        CfgGainRate:  cfg_d.gain_pitch_rate     = wdata_i;
        CfgGainTurn:  cfg_d.gain_turn_rate      = wdata_i;
        CfgGainAngle: cfg_d.gain_pitch_angle    = wdata_i;
        CfgGainSint:  cfg_d.gain_speed_integral = wdata_i;
        CfgGainTint:  cfg_d.gain_turn_integral  = wdata_i;
        CfgSpeedScl:  cfg_d.speed_scale         = wdata_i[ScaleW-1:0];
        CfgTurnScl:   cfg_d.turn_scale          = wdata_i[ScaleW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_forward_speed  <= -32'sd113204;
      cfg_q.gain_pitch_rate     <= -32'sd54403;
      cfg_q.gain_turn_rate      <= -32'sd8041;
      cfg_q.gain_pitch_angle    <= -32'sd282497;
      cfg_q.gain_speed_integral <= 32'sd1398;
      cfg_q.gain_turn_integral  <= 32'sd1372;
      cfg_q.speed_scale         <= 31'd1638;
      cfg_q.turn_scale          <= 31'd22898;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/lqr_integral_wheel_drive.sv -----
// Top level: LQR state feedback with integral action for a two-wheeled drive.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  in      | sink      | in_valid_i/in_stall_o | wheel speeds, tilt, targets
//  out     | source    | out_valid_o/out_stall_i| left and right effort
//  cfg     | sink      | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// A transfer in starts a run: the single shared multiplier forms eight products
// (two scalings, six gain terms), the gain terms accumulated from its product
// register; after a final step the result saturates into the output register.
// Reset: asynchronous, active low; gains and scales to defaults, integrators to zero.
// Stalls: a new item is taken while a result still waits; a run completes but
// holds its result until the output register is free.
module lqr_integral_wheel_drive (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lqrw_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lqrw_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [lqrw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lqrw_pkg::DataW-1:0]    cfg_wdata_i
);
  import lqrw_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StDone = 3'b100
  } state_e;

  // sequencer steps; each product lands in the step after its own
  localparam logic [3:0] StepFwd     = 4'd0;  // speed_scale * (l + r)
  localparam logic [3:0] StepTurn    = 4'd1;  // turn_scale * (l - r), fwd result back
  localparam logic [3:0] StepRate    = 4'd2;  // turn result back, speed integrator
  localparam logic [3:0] StepAngle   = 4'd3;  // turn integrator, first gain term
  localparam logic [3:0] StepGFwd    = 4'd4;
  localparam logic [3:0] StepGTurn   = 4'd5;
  localparam logic [3:0] StepGSint   = 4'd6;  // also turn-rate term accumulated
  localparam logic [3:0] StepGTint   = 4'd7;
  localparam logic [3:0] StepLast    = 4'd8;  // turn-integral term accumulated
  localparam logic [3:0] StepFinish  = 4'd9;

  state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;

  cfg_t cfg;
  in_t  item_q;
  out_t out_q;
  logic out_valid_q, out_valid_d;
  logic accept, load_out;

  logic signed [DataW-1:0] fwd_q, turn_q;
  logic signed [DataW-1:0] speed_sum_q, speed_sum_d, turn_sum_q, turn_sum_d;
  logic signed [AccW-1:0]  acc_l_q, acc_l_d, acc_r_q, acc_r_d;
  logic signed [OpW-1:0]   op_a, op_b;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  term, scaled;
  logic signed [DataW+1:0] int_speed, int_turn;
  logic                    neg_r;

  lqrw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  lqrw_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  assign accept   = in_valid_i && !in_stall_o;
  assign load_out = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  // operand selection for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_q == StRun) begin
      case (cnt_q)
        StepFwd: begin
          op_a = $signed({2'b00, cfg.speed_scale});
          op_b = OpW'(item_q.left_speed) + OpW'(item_q.right_speed);
        end
        StepTurn: begin
          op_a = $signed({2'b00, cfg.turn_scale});
          op_b = OpW'(item_q.left_speed) - OpW'(item_q.right_speed);
        end
        StepRate: begin
          op_a = OpW'(cfg.gain_pitch_rate);
          op_b = OpW'(item_q.tilt_rate);
        end
        StepAngle: begin
          op_a = OpW'(cfg.gain_pitch_angle);
          op_b = OpW'(item_q.tilt_angle);
        end
        StepGFwd: begin
          op_a = OpW'(cfg.gain_forward_speed);
          op_b = OpW'(fwd_q);
        end
        StepGTurn: begin
          op_a = OpW'(cfg.gain_turn_rate);
          op_b = OpW'(turn_q);
        end
        StepGSint: begin
          op_a = OpW'(cfg.gain_speed_integral);
          op_b = OpW'(speed_sum_q);
        end
        StepGTint: begin
          op_a = OpW'(cfg.gain_turn_integral);
          op_b = OpW'(turn_sum_q);
        end
        default: begin
          op_a = '0;
          op_b = '0;
        end
      endcase
    end
  end

  assign term   = AccW'(prod);
  assign scaled = AccW'(prod >>> FracBits);
  // right wheel takes the turn and turn-integral terms with opposite sign
  assign neg_r  = (cnt_q == StepGSint) || (cnt_q == StepLast);

  assign int_speed = (DataW+2)'(speed_sum_q) + (DataW+2)'(item_q.forward_speed_target)
                   - (DataW+2)'(fwd_q);
  assign int_turn  = (DataW+2)'(turn_sum_q) + (DataW+2)'(item_q.turn_rate_target)
                   - (DataW+2)'(turn_q);

  always_comb begin
    speed_sum_d = speed_sum_q;
    turn_sum_d  = turn_sum_q;
    acc_l_d     = acc_l_q;
    acc_r_d     = acc_r_q;
    if (state_q == StRun) begin
      if (cnt_q == StepRate) speed_sum_d = sat32(AccW'(int_speed));
      if (cnt_q == StepAngle) begin
        turn_sum_d = sat32(AccW'(int_turn));
        acc_l_d    = term;
        acc_r_d    = term;
      end else if (cnt_q > StepAngle && cnt_q <= StepLast) begin
        acc_l_d = acc_l_q + term;
        acc_r_d = neg_r ? acc_r_q - term : acc_r_q + term;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StRun;
          cnt_d   = StepFwd;
        end
      end
      StRun: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == StepFinish) state_d = StDone;
      end
      StDone: begin
        if (load_out) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      speed_sum_q <= '0;
      turn_sum_q  <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      speed_sum_q <= speed_sum_d;
      turn_sum_q  <= turn_sum_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_data_i;
    if (state_q == StRun && cnt_q == StepTurn) fwd_q  <= sat32(scaled);
    if (state_q == StRun && cnt_q == StepRate) turn_q <= sat32(scaled);
    acc_l_q <= acc_l_d;
    acc_r_q <= acc_r_d;
    if (load_out) begin
      out_q.left_effort  <= sat32(acc_l_q >>> FracBits);
      out_q.right_effort <= sat32(acc_r_q >>> FracBits);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StRun) && (cnt_q == StepFwd))
    else $error("transfer in did not start a run");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StDone))
    else $error("result raised outside completion");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (cnt_q <= StepFinish))
    else $error("step counter overran");

  a_sums_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |=> $stable(speed_sum_q) && $stable(turn_sum_q))
    else $error("integrator moved while idle");

endmodule
